// ===== rtl/zcws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package zcws_pkg;

    // Sample width of the audio stream
    localparam int unsigned SAMPLE_BITS = 16;
    localparam int unsigned WSIZE_BITS  = 16;
    localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 16'd1024;
    localparam logic [WSIZE_BITS-1:0] WSIZE_MIN   = 16'd2;

    // Result queue: three slots, so a last beat can drop two results in
    // while one is still waiting at the output
    localparam int unsigned QUEUE_DEPTH = 3;
    localparam logic [1:0]  QUEUE_LAST  = 2'd2;

    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_POS   = 2'd1,
        PH_NEG   = 2'd2,
        PH_ZERO  = 2'd3
    } phase_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          starts_window;
        logic                          last_out;
    } out_beat_t;

    // Magnitude, one bit wider so the most negative sample fits
    function automatic logic [SAMPLE_BITS:0] mag(input logic signed [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS:0] ext;
        ext = {v[SAMPLE_BITS-1], v};
        return v[SAMPLE_BITS-1] ? (~ext + 1'b1) : ext;
    endfunction

    // Queue pointer increment, wrapping over the three slots
    function automatic logic [1:0] inc3(input logic [1:0] p);
        return (p == QUEUE_LAST) ? 2'd0 : p + 2'd1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/zero_crossing_window_splitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Zero-crossing window splitter. Takes one signed sample per cycle and passes
// each sample out one input later, flagging the first sample of every window;
// a window runs at least the minimum window length (values below 2 act as 2)
// and then ends at the next sign change or zero, starting the new window on the
// smaller-magnitude side of the crossing (the later sample on a tie). A beat
// with last set releases any held sample and itself, so it yields one or two
// results back to back, and the next beat starts a fresh stream. All
// decisions are one compare and counter update per cycle, so the block
// sustains one sample per cycle; results sit in a three-slot output queue,
// and s_ready drops only while that queue holds two or more results. The
// minimum window length must be written through the cfg port while the block
// is idle, which it does not enforce; no clearing pass is needed after reset.
module zero_crossing_window_splitter (
    input  wire                        aclk,
    input  wire                        aresetn,
    // input samples
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire zcws_pkg::in_beat_t    s_data,
    // results
    output logic                       m_valid,
    input  wire                        m_ready,
    output zcws_pkg::out_beat_t        m_data,
    // minimum window length register
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire [zcws_pkg::WSIZE_BITS-1:0] cfg_data
);

    localparam int unsigned SB = zcws_pkg::SAMPLE_BITS;
    localparam int unsigned WB = zcws_pkg::WSIZE_BITS;

    // Configuration and stream state
    logic [WB-1:0]         wsize_reg;
    logic [WB-1:0]         offset_reg, offset_next;
    zcws_pkg::phase_t      phase_reg, phase_next;
    logic signed [SB-1:0]  held_reg, held_next;
    logic                  held_valid_reg, held_valid_next;
    logic                  held_starts_reg, held_starts_next;

    // Result queue
    zcws_pkg::out_beat_t   queue_reg [zcws_pkg::QUEUE_DEPTH];
    logic [1:0]            rd_ptr_reg, rd_ptr_next;
    logic [1:0]            wr_ptr_reg, wr_ptr_next;
    logic [1:0]            count_reg, count_next;

    logic                  in_acc, out_acc;
    logic [WB-1:0]         ws_eff;
    logic                  cur_starts;
    logic                  held_starts_upd;
    logic                  decide;
    logic                  push0, push1;
    logic [1:0]            wr1_idx;
    zcws_pkg::out_beat_t   held_entry, cur_entry;

    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready;
    assign out_acc   = m_valid && m_ready;
    assign ws_eff    = (wsize_reg < zcws_pkg::WSIZE_MIN) ? zcws_pkg::WSIZE_MIN : wsize_reg;

    // Crossing search decision
    always_comb begin
        unique case (phase_reg)
            zcws_pkg::PH_POS:  decide = (s_data.sample <= 0);
            zcws_pkg::PH_NEG:  decide = (s_data.sample >= 0);
            zcws_pkg::PH_ZERO: decide = 1'b1;
            default:           decide = 1'b0;
        endcase
    end

    // Next stream state
    always_comb begin
        offset_next      = offset_reg;
        phase_next       = phase_reg;
        cur_starts       = 1'b0;
        held_starts_upd  = held_starts_reg;
        if (phase_reg == zcws_pkg::PH_COUNT) begin
            cur_starts = (offset_reg == '0);
            if (offset_reg >= ws_eff) begin
                if (s_data.sample > 0)
                    phase_next = zcws_pkg::PH_POS;
                else if (s_data.sample < 0)
                    phase_next = zcws_pkg::PH_NEG;
                else
                    phase_next = zcws_pkg::PH_ZERO;
            end else begin
                offset_next = offset_reg + 1'b1;
            end
        end else if (decide) begin
            if (held_valid_reg && (zcws_pkg::mag(held_reg) < zcws_pkg::mag(s_data.sample))) begin
                held_starts_upd = 1'b1;
                offset_next     = WB'(2);
            end else begin
                cur_starts      = 1'b1;
                offset_next     = WB'(1);
            end
            phase_next = zcws_pkg::PH_COUNT;
        end

        held_next        = s_data.sample;
        held_valid_next  = 1'b1;
        held_starts_next = cur_starts;
        if (s_data.last) begin
            // stream ends: back to reset values
            offset_next      = '0;
            phase_next       = zcws_pkg::PH_COUNT;
            held_next        = '0;
            held_valid_next  = 1'b0;
            held_starts_next = 1'b1;
        end
    end

    // Results of this beat and queue bookkeeping
    always_comb begin
        held_entry.sample_out    = held_reg;
        held_entry.starts_window = held_starts_upd;
        held_entry.last_out      = 1'b0;
        cur_entry.sample_out     = s_data.sample;
        cur_entry.starts_window  = cur_starts;
        cur_entry.last_out       = 1'b1;

        push0   = in_acc && held_valid_reg;
        push1   = in_acc && s_data.last;
        wr1_idx = push0 ? zcws_pkg::inc3(wr_ptr_reg) : wr_ptr_reg;

        wr_ptr_next = wr_ptr_reg;
        if (push0 && push1)
            wr_ptr_next = zcws_pkg::inc3(zcws_pkg::inc3(wr_ptr_reg));
        else if (push0 || push1)
            wr_ptr_next = zcws_pkg::inc3(wr_ptr_reg);

        rd_ptr_next = out_acc ? zcws_pkg::inc3(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push0} + {1'b0, push1} - {1'b0, out_acc};
    end

    assign s_ready = (count_reg <= 2'd1);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = queue_reg[rd_ptr_reg];

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsize_reg       <= zcws_pkg::WSIZE_RESET;
            offset_reg      <= '0;
            phase_reg       <= zcws_pkg::PH_COUNT;
            held_valid_reg  <= 1'b0;
            held_starts_reg <= 1'b1;
            held_reg        <= '0;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            count_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_ready)
                wsize_reg <= cfg_data;
            if (in_acc) begin
                offset_reg      <= offset_next;
                phase_reg       <= phase_next;
                held_reg        <= held_next;
                held_valid_reg  <= held_valid_next;
                held_starts_reg <= held_starts_next;
            end
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue slots
    always_ff @(posedge aclk) begin
        if (push0)
            queue_reg[wr_ptr_reg] <= held_entry;
        if (push1)
            queue_reg[wr1_idx] <= cur_entry;
    end

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd3)
        else $error("result queue overfilled");

    a_search_has_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != zcws_pkg::PH_COUNT) |-> (held_valid_reg && offset_reg >= zcws_pkg::WSIZE_MIN))
        else $error("crossing search without a held sample");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_data.last) |=> (!held_valid_reg && phase_reg == zcws_pkg::PH_COUNT
                                     && offset_reg == '0))
        else $error("stream state not cleared after last");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("queue pointers disagree with empty count");

endmodule

`default_nettype wire

// ===== tb/zcws_checker.sv =====
`timescale 1ns / 1ps

// Watches the sample, result and configuration channels, tracks the splitter's
// window state and compares every result beat with the oldest expected one.
module zcws_checker (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    input  wire                              s_ready,
    input  zcws_pkg::in_beat_t               s_data,
    input  wire                              m_valid,
    input  wire                              m_ready,
    input  zcws_pkg::out_beat_t              m_data,
    input  wire                              cfg_valid,
    input  wire                              cfg_ready,
    input  wire [zcws_pkg::WSIZE_BITS-1:0]   cfg_data,
    output int                               fail_count,
    output int                               pending
);

    // Tracked copy of the splitter state
    logic [zcws_pkg::WSIZE_BITS-1:0]         min_window;
    logic [zcws_pkg::WSIZE_BITS-1:0]         window_offset;
    zcws_pkg::phase_t                        phase;
    logic signed [zcws_pkg::SAMPLE_BITS-1:0] held_sample;
    logic                                    held_valid;
    logic                                    held_starts;

    zcws_pkg::out_beat_t expected_beats[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic int magnitude(input logic signed [zcws_pkg::SAMPLE_BITS-1:0] v);
        int w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    function automatic zcws_pkg::phase_t sign_class(
        input logic signed [zcws_pkg::SAMPLE_BITS-1:0] v);
        if (v > 0)
            return zcws_pkg::PH_POS;
        else if (v < 0)
            return zcws_pkg::PH_NEG;
        return zcws_pkg::PH_ZERO;
    endfunction

    // New stream: first sample starts a window
    task automatic clear_stream();
        window_offset = '0;
        phase         = zcws_pkg::PH_COUNT;
        held_sample   = '0;
        held_valid    = 1'b0;
        held_starts   = 1'b1;
    endtask

    // Advance the window state by one sample and queue the beats it releases
    task automatic predict_beats(input zcws_pkg::in_beat_t b);
        logic [zcws_pkg::WSIZE_BITS-1:0]         eff_size;
        logic signed [zcws_pkg::SAMPLE_BITS-1:0] x;
        logic                                    cur_starts;
        logic                                    decide;
        zcws_pkg::out_beat_t                     r;
        x          = b.sample;
        eff_size   = (min_window < zcws_pkg::WSIZE_MIN) ? zcws_pkg::WSIZE_MIN : min_window;
        cur_starts = 1'b0;
        if (phase == zcws_pkg::PH_COUNT) begin
            if (window_offset == 0)
                cur_starts = 1'b1;
            // candidate: first sample at or past the minimum length
            if (window_offset >= eff_size)
                phase = sign_class(x);
            else
                window_offset = window_offset + 1'b1;
        end else begin
            case (phase)
                zcws_pkg::PH_POS: decide = (x <= 0);
                zcws_pkg::PH_NEG: decide = (x >= 0);
                default:          decide = 1'b1;
            endcase
            if (decide) begin
                // new window on the smaller side, later sample on a tie
                if (held_valid && magnitude(held_sample) < magnitude(x)) begin
                    held_starts   = 1'b1;
                    window_offset = 16'd2;
                end else begin
                    cur_starts    = 1'b1;
                    window_offset = 16'd1;
                end
                phase = zcws_pkg::PH_COUNT;
            end
        end

        if (held_valid) begin
            r.sample_out    = held_sample;
            r.starts_window = held_starts;
            r.last_out      = 1'b0;
            expected_beats.push_back(r);
        end

        if (b.last) begin
            r.sample_out    = x;
            r.starts_window = cur_starts;
            r.last_out      = 1'b1;
            expected_beats.push_back(r);
            clear_stream();
        end else begin
            held_sample = x;
            held_valid  = 1'b1;
            held_starts = cur_starts;
        end
    endtask

    task automatic check_result(input zcws_pkg::out_beat_t got);
        zcws_pkg::out_beat_t want;
        if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: sample_out %0d starts_window %0b %s %0b",
                   got.sample_out, got.starts_window, "last_out", got.last_out);
            fail_count++;
        end else begin
            want = expected_beats.pop_front();
            if (got.sample_out !== want.sample_out) begin
                $error("sample_out: expected %0d, got %0d", want.sample_out, got.sample_out);
                fail_count++;
            end
            if (got.starts_window !== want.starts_window) begin
                $error("starts_window: expected %0b, got %0b",
                       want.starts_window, got.starts_window);
                fail_count++;
            end
            if (got.last_out !== want.last_out) begin
                $error("last_out: expected %0b, got %0b", want.last_out, got.last_out);
                fail_count++;
            end
        end
    endtask

    // Results are checked before the same edge's sample is predicted; a
    // register write at this edge only affects later samples
    always @(posedge aclk) begin
        if (!aresetn) begin
            min_window = zcws_pkg::WSIZE_RESET;
            clear_stream();
            expected_beats.delete();
        end else begin
            if (m_valid && m_ready)
                check_result(m_data);
            if (s_valid && s_ready)
                predict_beats(s_data);
            if (cfg_valid && cfg_ready)
                min_window = cfg_data;
        end
        pending = expected_beats.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE      = 8;
    localparam int NUM_PHASES  = 10;
    localparam int NUM_DIRECT  = 25;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    zcws_pkg::in_beat_t              s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    zcws_pkg::out_beat_t             m_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [zcws_pkg::WSIZE_BITS-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    // Sender burst and tone-run state
    int burst_left = 0;
    int run_left   = 0;
    bit run_neg    = 1'b0;

    // Receiver stall pattern state
    int   ready_run   = 0;
    int   ready_stall = 0;
    logic ready_next;

    // Directed beats: extremes, ties, zero candidates, stream ends
    int dir_sample[NUM_DIRECT] = '{32767, -32768, 32767, 32767, -32768, 0, 7, 5, -5, -3,
                                   -1, -2, 0, -1, 1, 10, 20, 1, 2, 3,
                                   4, 0, 0, 0, 0};
    bit dir_last[NUM_DIRECT]   = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                   0, 0, 1, 1, 1, 0, 1, 0, 0, 0,
                                   1, 0, 0, 0, 1};

    // Random phases: minimum window length, beats, percent of stream ends, gaps on
    int ph_size[NUM_PHASES]  = '{0, 1, 3, 2, 16, 65535, 5, 37, 100, 0};
    int ph_beats[NUM_PHASES] = '{150, 150, 200, 150, 250, 40, 200, 250, 200, 160};
    int ph_last[NUM_PHASES]  = '{3, 3, 2, 5, 1, 0, 2, 1, 1, 2};
    bit ph_gaps[NUM_PHASES]  = '{1, 1, 0, 1, 1, 1, 1, 0, 1, 1};

    zero_crossing_window_splitter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    zcws_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Receiver: ready runs of random length, short stalls, now and then a long run
    always @(posedge aclk) begin
        if (ready_run > 0) begin
            ready_next = 1'b1;
            ready_run--;
        end else if (ready_stall > 0) begin
            ready_next = 1'b0;
            ready_stall--;
        end else begin
            ready_next  = 1'b1;
            ready_run   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                      : $urandom_range(0, 20);
            ready_stall = $urandom_range(1, 6);
        end
        m_ready <= ready_next;
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Tone-like samples: runs of one sign with mixed magnitudes, some noise
    function automatic zcws_pkg::in_beat_t next_sample(input int max_run, input int last_pct);
        zcws_pkg::in_beat_t b;
        int                 mag_val;
        if (run_left == 0) begin
            run_left = $urandom_range(1, max_run);
            if ($urandom_range(0, 4) != 0)
                run_neg = !run_neg;
        end
        run_left--;
        case ($urandom_range(0, 9))
            0:       mag_val = 0;
            1:       mag_val = run_neg ? 32768 : 32767;
            2, 3, 4: mag_val = $urandom_range(1, 8);
            default: mag_val = $urandom_range(1, 32767);
        endcase
        if ($urandom_range(0, 9) == 0)
            b.sample = zcws_pkg::SAMPLE_BITS'($urandom_range(0, 65535));
        else
            b.sample = zcws_pkg::SAMPLE_BITS'(run_neg ? -mag_val : mag_val);
        b.last = ($urandom_range(0, 99) < last_pct);
        if (b.last)
            run_left = 0;
        return b;
    endfunction

    // Ends at the accepting edge with valid still high unless a gap follows
    task automatic send_sample(input zcws_pkg::in_beat_t b, input bit gaps);
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Hold the sender until every expected result is out, then let the block settle
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_min_window(input logic [zcws_pkg::WSIZE_BITS-1:0] size);
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        zcws_pkg::in_beat_t b;
        int                 max_run;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats at the smallest window
        write_min_window(16'd2);
        for (int i = 0; i < NUM_DIRECT; i++) begin
            b.sample = zcws_pkg::SAMPLE_BITS'(dir_sample[i]);
            b.last   = dir_last[i];
            send_sample(b, 1'b0);
        end
        wait_for_results();

        // Random phases; size changes land mid-stream, so a window can shrink
        ph_size[NUM_PHASES-1] = $urandom_range(2, 12);
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_min_window(zcws_pkg::WSIZE_BITS'(ph_size[p]));
            max_run = (ph_size[p] < 4) ? 4 : ((ph_size[p] > 60) ? 60 : ph_size[p]);
            for (int i = 0; i < ph_beats[p]; i++) begin
                b = next_sample(max_run, ph_last[p]);
                send_sample(b, ph_gaps[p]);
                if ($urandom_range(0, 149) == 0)
                    wait_for_results();
            end
            wait_for_results();
        end

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
